// ===== src/fmgs_pkg.sv =====
// Shared constants, types and helpers for the free-map group summarizer.
package fmgs_pkg;

    localparam int FRAGS_PER_BLOCK = 8;
    localparam int CONTIG_MAX      = 16;
    localparam int COUNT_WIDTH     = 24;

    localparam int CMD_W    = 2;
    localparam int FRAG_W   = 8;
    localparam int INODE_W  = 8;
    localparam int INCNT_W  = 4;
    localparam int LIMIT_W  = 5;
    localparam int KIND_W   = 3;
    localparam int BUCKET_W = 5;

    localparam int HIST_N      = FRAGS_PER_BLOCK - 1;
    localparam int HIST_IDX_W  = $clog2(HIST_N);
    localparam int CL_IDX_W    = $clog2(CONTIG_MAX);
    localparam int FRAG_CNT_W  = $clog2(FRAGS_PER_BLOCK + 1);
    localparam int HIST_INC_W  = $clog2(FRAGS_PER_BLOCK / 2 + 1);
    localparam int INODE_CNT_W = $clog2(INODE_W + 1);

    // fixed report entries: three totals plus the fragment run buckets
    localparam int REPORT_FIXED = 3 + HIST_N;
    localparam int REPORT_W     = $clog2(REPORT_FIXED + CONTIG_MAX);

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_BLOCK  = 2'd0,
        CMD_INODE  = 2'd1,
        CMD_FINISH = 2'd2
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_FREE_BLOCKS = 3'd0,
        KIND_FREE_FRAGS  = 3'd1,
        KIND_FREE_INODES = 3'd2,
        KIND_FRAG_HIST   = 3'd3,
        KIND_CLUSTER     = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        OP_BLOCK,
        OP_INODE,
        OP_FINISH
    } t_op_kind;

    typedef enum logic {
        ST_RUN,
        ST_REPORT
    } t_state;

    typedef struct packed {
        t_op_kind                             kind;
        logic                                 full;
        logic [FRAG_CNT_W-1:0]                frag_cnt;
        logic [HIST_N-1:0][HIST_INC_W-1:0]    hist_inc;
        logic [INODE_CNT_W-1:0]               inode_cnt;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_push;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    function automatic logic [COUNT_WIDTH-1:0] sat_add(
        input logic [COUNT_WIDTH-1:0] a,
        input logic [COUNT_WIDTH-1:0] b
    );
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
    endfunction

endpackage

// ===== src/fmgs_in_if.sv =====
// Input item channel: valid/ready plus the bitmap command payload.
interface fmgs_in_if import fmgs_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [FRAG_W-1:0]  frag_free_bits;
    logic [INODE_W-1:0] inode_used_bits;
    logic [INCNT_W-1:0] inode_bit_count;

    modport source (output valid, command, frag_free_bits, inode_used_bits,
                    inode_bit_count, input ready);
    modport sink   (input valid, command, frag_free_bits, inode_used_bits,
                    inode_bit_count, output ready);
endinterface

// ===== src/fmgs_out_if.sv =====
// Result channel: valid/ready plus one report entry.
interface fmgs_out_if import fmgs_pkg::*; ;
    logic                   valid;
    logic                   ready;
    logic [KIND_W-1:0]      kind;
    logic [BUCKET_W-1:0]    bucket;
    logic [COUNT_WIDTH-1:0] count;
    logic                   last;

    modport source (output valid, kind, bucket, count, last, input ready);
    modport sink   (input valid, kind, bucket, count, last, output ready);
endinterface

// ===== src/free_map_group_summarizer_top.sv =====
// Flow: a taken block or inode transfer is written to the op queue and applied to the
//   counters when the back end pops it; a popped finish moves the back end to the report state.
// Throughput: one block or inode transfer per cycle while the op queue is not full; a finish
//   transfer streams 10 + limit results (limit = min(contig_limit, 16)), one per cycle while
//   the receiver is ready, during which queued transfers wait and the 4-entry op queue fills.
// Reset: synchronous active-low; clears all counts and histograms and sets
//   contig_limit to 16.
module free_map_group_summarizer_top import fmgs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fmgs_in_if.sink            i_in,
    fmgs_out_if.source         o_out,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_data
);

    t_push     push;
    t_op       head;
    t_q_status q_status;
    logic      pop;

    fmgs_front u_front (
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (push)
    );

    fmgs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    fmgs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_head     (head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

// ===== src/fmgs_front.sv =====
// Front end: takes input transfers and classifies each block, inode or finish into a queued op.
module fmgs_front import fmgs_pkg::*; (
    fmgs_in_if.sink   i_in,
    input  t_q_status i_q_status,
    output t_push     o_push
);

    logic [FRAGS_PER_BLOCK-1:0] bits;
    logic [FRAGS_PER_BLOCK+1:0] pad;
    logic [INCNT_W-1:0]         n_eff;
    t_op                        op;
    logic                       accept;

    assign i_in.ready = !i_q_status.full;
    assign accept     = i_in.valid && i_in.ready;

    assign bits  = i_in.frag_free_bits[FRAGS_PER_BLOCK-1:0];
    assign pad   = {1'b0, bits, 1'b0};
    assign n_eff = (i_in.inode_bit_count > INCNT_W'(INODE_W)) ?
                   INCNT_W'(INODE_W) : i_in.inode_bit_count;

    always_comb begin
        logic ok;
        op           = '0;
        op.kind      = OP_BLOCK;
        op.full      = &bits;
        for (int f = 0; f < FRAGS_PER_BLOCK; f++) begin
            op.frag_cnt = op.frag_cnt + FRAG_CNT_W'(bits[f]);
        end
        // a run of exactly l free fragments starting at s: bounded by used bits or the block edges
        for (int l = 1; l <= HIST_N; l++) begin
            for (int s = 0; s + l <= FRAGS_PER_BLOCK; s++) begin
                ok = !pad[s] && !pad[s+l+1];
                for (int k = 1; k <= l; k++) begin
                    ok = ok && pad[s+k];
                end
                op.hist_inc[l-1] = op.hist_inc[l-1] + HIST_INC_W'(ok);
            end
        end
        for (int i = 0; i < INODE_W; i++) begin
            if ((INCNT_W'(i) < n_eff) && !i_in.inode_used_bits[i]) begin
                op.inode_cnt = op.inode_cnt + INODE_CNT_W'(1);
            end
        end
        unique case (i_in.command)
            CMD_BLOCK:  op.kind = OP_BLOCK;
            CMD_INODE:  op.kind = OP_INODE;
            CMD_FINISH: op.kind = OP_FINISH;
            default:    op.kind = OP_BLOCK;
        endcase
    end

    // unused command code is accepted and dropped
    always_comb begin
        o_push.valid = accept && (i_in.command == CMD_BLOCK ||
                                  i_in.command == CMD_INODE ||
                                  i_in.command == CMD_FINISH);
        o_push.op    = op;
    end

endmodule

// ===== src/fmgs_queue.sv =====
// Small op queue between the classifier and the accumulator.
module fmgs_queue import fmgs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    input  logic      i_pop,
    output t_op       o_head,
    output t_q_status o_status
);

    t_op                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count, n_count;
    logic               do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_head         = r_mem[r_rd_ptr];
    assign do_pop         = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = r_wr_ptr + Q_PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = r_rd_ptr + Q_PTR_W'(1);
        end
        case ({i_push.valid, do_pop})
            2'b10:   n_count = r_count + Q_CNT_W'(1);
            2'b01:   n_count = r_count - Q_CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.op;
        end
    end

endmodule

// ===== src/fmgs_back.sv =====
// Back end: applies ops to the counters and streams out the group report.
module fmgs_back import fmgs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [LIMIT_W-1:0]  i_cfg_data,
    input  t_op                 i_head,
    input  t_q_status           i_q_status,
    output logic                o_pop,
    fmgs_out_if.source          o_out
);

    logic [LIMIT_W-1:0]     r_contig_limit;
    logic [COUNT_WIDTH-1:0] r_free_blocks, r_free_frags, r_free_inodes, r_cluster_run;
    logic [COUNT_WIDTH-1:0] r_frag_hist    [HIST_N];
    logic [COUNT_WIDTH-1:0] r_cluster_hist [CONTIG_MAX];
    logic [REPORT_W-1:0]    r_idx;
    t_state                 r_state, n_state;

    logic                   r_out_valid;
    t_kind                  r_kind, n_kind;
    logic [BUCKET_W-1:0]    r_bucket, n_bucket;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_last, n_last;

    logic                   pop, load, is_last;
    logic [LIMIT_W-1:0]     lim;
    logic [LIMIT_W-1:0]     cl_bucket;
    logic [CL_IDX_W-1:0]    cl_idx;
    logic                   cl_close;
    logic [REPORT_W-1:0]    hist_off, cl_off;

    assign lim = (r_contig_limit > LIMIT_W'(CONTIG_MAX)) ? LIMIT_W'(CONTIG_MAX)
                                                          : r_contig_limit;

    // ---- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (pop && i_head.kind == OP_FINISH) begin
                    n_state = ST_REPORT;
                end
            end
            ST_REPORT: begin
                if (load && is_last) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    // ---- control outputs
    always_comb begin
        pop  = 1'b0;
        load = 1'b0;
        unique case (r_state)
            ST_RUN:    pop  = !i_q_status.empty;
            ST_REPORT: load = !r_out_valid || o_out.ready;
            default: begin
                pop  = 1'b0;
                load = 1'b0;
            end
        endcase
    end
    assign o_pop = pop;

    // cluster run closes on a not fully free block or on finish
    assign cl_close  = pop && ((i_head.kind == OP_BLOCK && !i_head.full) ||
                               i_head.kind == OP_FINISH) &&
                       (r_cluster_run != '0) && (lim != '0);
    assign cl_bucket = (r_cluster_run < COUNT_WIDTH'(lim)) ?
                       r_cluster_run[LIMIT_W-1:0] : lim;
    assign cl_idx    = CL_IDX_W'(cl_bucket - LIMIT_W'(1));

    // report entry selection
    assign is_last  = ({1'b0, r_idx} + (REPORT_W+1)'(1)) ==
                      ((REPORT_W+1)'(REPORT_FIXED) + (REPORT_W+1)'(lim));
    assign hist_off = r_idx - REPORT_W'(3);
    assign cl_off   = r_idx - REPORT_W'(REPORT_FIXED);

    always_comb begin
        n_kind   = KIND_FREE_BLOCKS;
        n_bucket = '0;
        n_count  = r_free_blocks;
        n_last   = is_last;
        if (r_idx == REPORT_W'(1)) begin
            n_kind  = KIND_FREE_FRAGS;
            n_count = r_free_frags;
        end else if (r_idx == REPORT_W'(2)) begin
            n_kind  = KIND_FREE_INODES;
            n_count = r_free_inodes;
        end else if (r_idx >= REPORT_W'(3) && r_idx < REPORT_W'(REPORT_FIXED)) begin
            n_kind   = KIND_FRAG_HIST;
            n_bucket = BUCKET_W'(hist_off + REPORT_W'(1));
            n_count  = r_frag_hist[hist_off[HIST_IDX_W-1:0]];
        end else if (r_idx >= REPORT_W'(REPORT_FIXED)) begin
            n_kind   = KIND_CLUSTER;
            n_bucket = BUCKET_W'(cl_off + REPORT_W'(1));
            n_count  = r_cluster_hist[cl_off[CL_IDX_W-1:0]];
        end
    end

    // ---- control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_RUN;
            r_idx          <= '0;
            r_out_valid    <= 1'b0;
            r_contig_limit <= LIMIT_W'(CONTIG_MAX);
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_contig_limit <= i_cfg_data;
            end
            if (load) begin
                r_idx <= is_last ? '0 : r_idx + REPORT_W'(1);
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---- counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (load && is_last)) begin
            r_free_blocks <= '0;
            r_free_frags  <= '0;
            r_free_inodes <= '0;
            r_cluster_run <= '0;
            for (int i = 0; i < HIST_N; i++) begin
                r_frag_hist[i] <= '0;
            end
            for (int i = 0; i < CONTIG_MAX; i++) begin
                r_cluster_hist[i] <= '0;
            end
        end else if (pop) begin
            if (cl_close) begin
                r_cluster_hist[cl_idx] <= sat_add(r_cluster_hist[cl_idx],
                                                  COUNT_WIDTH'(1));
            end
            case (i_head.kind)
                OP_BLOCK: begin
                    if (i_head.full) begin
                        r_free_blocks <= sat_add(r_free_blocks, COUNT_WIDTH'(1));
                        r_cluster_run <= sat_add(r_cluster_run, COUNT_WIDTH'(1));
                    end else begin
                        r_free_frags  <= sat_add(r_free_frags,
                                                 COUNT_WIDTH'(i_head.frag_cnt));
                        r_cluster_run <= '0;
                        for (int i = 0; i < HIST_N; i++) begin
                            r_frag_hist[i] <= sat_add(r_frag_hist[i],
                                                      COUNT_WIDTH'(i_head.hist_inc[i]));
                        end
                    end
                end
                OP_INODE: begin
                    r_free_inodes <= sat_add(r_free_inodes,
                                             COUNT_WIDTH'(i_head.inode_cnt));
                end
                OP_FINISH: r_cluster_run <= '0;
                default:   r_cluster_run <= r_cluster_run;
            endcase
        end
    end

    // ---- output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind   <= n_kind;
            r_bucket <= n_bucket;
            r_count  <= n_count;
            r_last   <= n_last;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.kind   = r_kind;
    assign o_out.bucket = r_bucket;
    assign o_out.count  = r_count;
    assign o_out.last   = r_last;

endmodule

// ===== sim/tb_free_map_group_summarizer_top.sv =====
// Self-checking testbench for the free-map group summarizer: directed table, then random phases.
module tb_free_map_group_summarizer_top;
    import fmgs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0]   CMD_UNUSED = 2'd3;
    localparam logic [COUNT_WIDTH-1:0] CNT_TOP = {COUNT_WIDTH{1'b1}};
    localparam int N_PLAN       = 16;
    localparam int PHASE_ITEMS  = 60;
    localparam int HOLD_CYCLES  = 200;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [FRAG_W-1:0]  frag;
        logic [INODE_W-1:0] inode;
        logic [INCNT_W-1:0] icnt;
    } t_item;

    // typed = 1: the free block total of the report is given by hand
    typedef struct packed {
        t_item                  item;
        logic                   typed;
        logic [COUNT_WIDTH-1:0] blocks_exp;
    } t_row;

    typedef struct packed {
        t_kind                  kind;
        logic [BUCKET_W-1:0]    bucket;
        logic [COUNT_WIDTH-1:0] count;
        logic                   last;
    } t_entry;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [LIMIT_W-1:0] i_cfg_data;

    fmgs_in_if  in_ch ();
    fmgs_out_if out_ch ();

    free_map_group_summarizer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

    // mirror of the block's counters
    logic [COUNT_WIDTH-1:0] blocks_free;
    logic [COUNT_WIDTH-1:0] frags_free;
    logic [COUNT_WIDTH-1:0] inodes_free;
    logic [COUNT_WIDTH-1:0] run_hist [1:HIST_N];
    logic [COUNT_WIDTH-1:0] clus_hist [1:CONTIG_MAX];
    logic [COUNT_WIDTH-1:0] clus_run;
    logic [LIMIT_W-1:0]     limit_reg;

    t_entry report_q [$];
    int     mismatches = 0;
    bit     hold_req = 1'b0;

    t_row plan [0:N_PLAN-1] = '{
        '{'{CMD_FINISH, 8'h00, 8'h00, 4'd0}, 1'b1, 24'd0},
        '{'{CMD_BLOCK,  8'hFF, 8'h00, 4'd0}, 1'b0, 24'd0},
        '{'{CMD_BLOCK,  8'hFF, 8'hFF, 4'd15}, 1'b0, 24'd0},
        '{'{CMD_BLOCK,  8'h00, 8'h00, 4'd0}, 1'b0, 24'd0},
        '{'{CMD_BLOCK,  8'hFE, 8'h00, 4'd0}, 1'b0, 24'd0},
        '{'{CMD_BLOCK,  8'h7F, 8'h00, 4'd0}, 1'b0, 24'd0},
        '{'{CMD_BLOCK,  8'h55, 8'h00, 4'd0}, 1'b0, 24'd0},
        '{'{CMD_BLOCK,  8'h81, 8'h00, 4'd0}, 1'b0, 24'd0},
        '{'{CMD_INODE,  8'hFF, 8'h00, 4'd8}, 1'b0, 24'd0},
        '{'{CMD_INODE,  8'h00, 8'hFF, 4'd8}, 1'b0, 24'd0},
        '{'{CMD_INODE,  8'h00, 8'h0F, 4'd15}, 1'b0, 24'd0},
        '{'{CMD_INODE,  8'h00, 8'hAA, 4'd0}, 1'b0, 24'd0},
        '{'{CMD_INODE,  8'h00, 8'h00, 4'd9}, 1'b0, 24'd0},
        '{'{CMD_UNUSED, 8'hFF, 8'hFF, 4'd15}, 1'b0, 24'd0},
        '{'{CMD_FINISH, 8'h00, 8'h00, 4'd0}, 1'b1, 24'd2},
        '{'{CMD_FINISH, 8'h00, 8'h00, 4'd0}, 1'b1, 24'd0}
    };

    function automatic logic [COUNT_WIDTH-1:0] grow(logic [COUNT_WIDTH-1:0] a, int unsigned b);
        longint unsigned s;
        s = longint'(a) + b;
        return (s > CNT_TOP) ? CNT_TOP : s[COUNT_WIDTH-1:0];
    endfunction

    function automatic int unsigned tracked_limit();
        return (limit_reg > CONTIG_MAX) ? CONTIG_MAX : limit_reg;
    endfunction

    task automatic clear_counts();
        blocks_free = '0;
        frags_free  = '0;
        inodes_free = '0;
        clus_run    = '0;
        for (int b = 1; b <= HIST_N; b++) run_hist[b] = '0;
        for (int b = 1; b <= CONTIG_MAX; b++) clus_hist[b] = '0;
    endtask

    task automatic close_run();
        int unsigned lim;
        int unsigned b;
        lim = tracked_limit();
        if (clus_run != 0 && lim != 0) begin
            b = (clus_run < lim) ? clus_run : lim;
            clus_hist[b] = grow(clus_hist[b], 1);
        end
        clus_run = '0;
    endtask

    task automatic post(t_kind k, int unsigned b, logic [COUNT_WIDTH-1:0] c);
        t_entry e;
        e.kind   = k;
        e.bucket = b[BUCKET_W-1:0];
        e.count  = c;
        e.last   = 1'b0;
        report_q.insert(report_q.size(), e);
    endtask

    // apply one accepted item; a finish appends its report to report_q
    task automatic summarize(t_item it);
        int unsigned free_n;
        int unsigned run;
        int unsigned n;
        if (it.cmd == CMD_BLOCK) begin
            if (it.frag == 8'hFF) begin
                blocks_free = grow(blocks_free, 1);
                clus_run    = grow(clus_run, 1);
            end else begin
                free_n = 0;
                run    = 0;
                for (int f = 0; f < FRAGS_PER_BLOCK; f++) begin
                    if (it.frag[f]) begin
                        free_n++;
                        run++;
                    end else if (run != 0) begin
                        run_hist[run] = grow(run_hist[run], 1);
                        run = 0;
                    end
                end
                if (run != 0) run_hist[run] = grow(run_hist[run], 1);
                frags_free = grow(frags_free, free_n);
                close_run();
            end
        end else if (it.cmd == CMD_INODE) begin
            n = (it.icnt > INODE_W) ? INODE_W : it.icnt;
            free_n = 0;
            for (int i = 0; i < n; i++)
                if (!it.inode[i]) free_n++;
            inodes_free = grow(inodes_free, free_n);
        end else if (it.cmd == CMD_FINISH) begin
            close_run();
            post(KIND_FREE_BLOCKS, 0, blocks_free);
            post(KIND_FREE_FRAGS, 0, frags_free);
            post(KIND_FREE_INODES, 0, inodes_free);
            for (int b = 1; b <= HIST_N; b++) post(KIND_FRAG_HIST, b, run_hist[b]);
            for (int b = 1; b <= tracked_limit(); b++) post(KIND_CLUSTER, b, clus_hist[b]);
            report_q[report_q.size()-1].last = 1'b1;
            clear_counts();
        end
    endtask

    // offer one item after an idle gap set by 'gap' and wait for its transfer
    task automatic offer(t_item it, int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.command         <= it.cmd;
        in_ch.frag_free_bits  <= it.frag;
        in_ch.inode_used_bits <= it.inode;
        in_ch.inode_bit_count <= it.icnt;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    function automatic t_item random_item();
        t_item it;
        int unsigned pick;
        it.frag  = 8'($urandom_range(0, 255));
        it.inode = 8'($urandom_range(0, 255));
        it.icnt  = ($urandom_range(0, 2) != 0) ? 4'd8 : 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            it.cmd = CMD_BLOCK;
            // lots of fully free blocks so cluster runs get long
            pick = $urandom_range(0, 9);
            if (pick < 4)       it.frag = 8'hFF;
            else if (pick == 4) it.frag = 8'h00;
        end else if (pick < 88) begin
            it.cmd = CMD_INODE;
        end else if (pick < 97) begin
            it.cmd = CMD_FINISH;
        end else begin
            it.cmd = CMD_UNUSED;
        end
        return it;
    endfunction

    task automatic write_limit(logic [LIMIT_W-1:0] v);
        in_ch.valid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        limit_reg = v;
        i_cfg_we <= 1'b0;
    endtask

    // receiver: changing stall patterns, plus one long hold-off on request
    initial begin
        int hold_left;
        int mode;
        int mode_left;
        int cyc;
        logic rdy;
        hold_left = 0;
        mode = 0;
        mode_left = 0;
        cyc = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (mode)
                    0: rdy = 1'b1;
                    1: rdy = 1'($urandom_range(0, 1));
                    2: rdy = ($urandom_range(0, 3) == 0);
                    default: rdy = (cyc % 3 != 0);
                endcase
            end
            out_ch.ready <= rdy;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_entry e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (report_q.size() == 0) begin
                $display("%0t: unexpected result kind=%0d bucket=%0d count=%0d last=%0b",
                         $time, out_ch.kind, out_ch.bucket, out_ch.count, out_ch.last);
                mismatches++;
            end else begin
                e = report_q.pop_front();
                if (out_ch.kind !== e.kind || out_ch.bucket !== e.bucket ||
                    out_ch.count !== e.count || out_ch.last !== e.last) begin
                    $display("%0t: expected kind=%0d bucket=%0d count=%0d last=%0b, got kind=%0d bucket=%0d count=%0d last=%0b",
                             $time, e.kind, e.bucket, e.count, e.last,
                             out_ch.kind, out_ch.bucket, out_ch.count, out_ch.last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        logic [LIMIT_W-1:0] limits [0:6];
        int burst_left;
        int gap;
        int first;
        t_item it;

        limits[0] = 5'd0;
        limits[1] = 5'd1;
        limits[2] = 5'd31;
        limits[3] = 5'd5;
        limits[4] = 5'd17;
        limits[5] = 5'($urandom_range(0, 31));
        limits[6] = 5'd16;
        burst_left = 0;

        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_data            = '0;
        in_ch.valid           = 1'b0;
        in_ch.command         = CMD_BLOCK;
        in_ch.frag_free_bits  = '0;
        in_ch.inode_used_bits = '0;
        in_ch.inode_bit_count = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        limit_reg = 5'd16;
        clear_counts();
        @(posedge i_clk);

        for (int r = 0; r < N_PLAN; r++) begin
            offer(plan[r].item, $urandom_range(0, 2));
            first = report_q.size();
            summarize(plan[r].item);
            if (plan[r].typed) report_q[first].count = plan[r].blocks_exp;
        end

        for (int p = 0; p < 7; p++) begin
            write_limit(limits[p]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                it = random_item();
                // the hold-off phase opens with a finish so the op queue backs up
                if (p == 2 && k == 0) begin
                    hold_req = 1'b1;
                    it.cmd   = CMD_FINISH;
                end
                if (k == PHASE_ITEMS - 1) it.cmd = CMD_FINISH;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    gap = 0;
                end
                burst_left--;
                offer(it, gap);
                summarize(it);
            end
        end

        in_ch.valid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && report_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/fmgs_pkg.sv
src/fmgs_in_if.sv
src/fmgs_out_if.sv
src/fmgs_front.sv
src/fmgs_queue.sv
src/fmgs_back.sv
src/free_map_group_summarizer_top.sv
sim/tb_free_map_group_summarizer_top.sv
